// ===== src/rri_pkg.sv =====
`timescale 1ns / 1ps

package rri_pkg;

    localparam int CoordW   = 16;
    localparam int VecW     = 3 * CoordW;
    localparam int LenW     = 34;
    localparam int EpsW     = 16;
    localparam int DistW    = 32;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 48;

    // Intermediate widths, sized to the worst case of the Q8.8 inputs.
    localparam int NumW  = 35;   // signed dot(corner - origin, normal)
    localparam int DenW  = 34;   // signed dot(dir, normal)
    localparam int NMagW = 34;   // |num|
    localparam int DMagW = 33;   // |den|
    localparam int RemW  = 34;   // partial remainder, below 2 * |den|
    localparam int PtW   = 34;   // wide hit point
    localparam int OffW  = 35;   // point minus corner
    localparam int PrdW  = 51;   // offset times edge component
    localparam int DotW  = 53;   // sum of three such products

    typedef enum logic [CfgIdxW-1:0] {
        REG_CORNER = 3'd0,
        REG_EDGE_A = 3'd1,
        REG_EDGE_B = 3'd2,
        REG_NORMAL = 3'd3,
        REG_LEN_A  = 3'd4,
        REG_LEN_B  = 3'd5,
        REG_EPS    = 3'd6,
        REG_SHADOW = 3'd7
    } reg_idx_t;

    // Clamp a wide signed point component to a signed 16-bit value.
    function automatic logic signed [CoordW-1:0] sat16(input logic signed [PtW-1:0] v);
        logic signed [PtW-1:0] hi;
        logic signed [PtW-1:0] lo;
        hi = {{(PtW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
        lo = {{(PtW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};
        if (v > hi) begin
            sat16 = hi[CoordW-1:0];
        end else if (v < lo) begin
            sat16 = lo[CoordW-1:0];
        end else begin
            sat16 = v[CoordW-1:0];
        end
    endfunction

endpackage

// ===== src/ray_rectangle_intersect.sv =====
`timescale 1ns / 1ps

// Ray against rectangle intersection, one ray per cycle while the output is not stalled.
//
// Software loads the rectangle over the cfg_ channel (index 0 corner, 1 and 2
// the edge vectors, 3 the unit normal, 4 and 5 the squared edge lengths,
// 6 epsilon, 7 the shadow enable). A configuration transfer must be made
// only while no ray is in flight, not enforced by the block; cfg_ready is always high.
// Rays arrive on the s_ channel with a query kind (0 primary, 1 shadow) and
// every ray yields exactly one result on the m_ channel, in order.
// On a miss the hit flag, distance and point are all zero.
//
// Most of the pipeline forms the plane distance quotient, which a 32-stage
// restoring divider forms one quotient bit per stage; the rest are the dot
// products, the hit point and the inside test. Throughput is one ray per
// cycle while the output is not stalled.
//
// The whole pipeline advances together: when m_valid is high and m_ready is
// low, every stage holds and s_ready drops, so no ray is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: all geometry zero, epsilon one, shadows enabled.
module ray_rectangle_intersect
    import rri_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CfgIdxW-1:0]         cfg_index,
    input  logic [CfgDataW-1:0]        cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [CoordW-1:0]   s_origin_x,
    input  logic signed [CoordW-1:0]   s_origin_y,
    input  logic signed [CoordW-1:0]   s_origin_z,
    input  logic signed [CoordW-1:0]   s_dir_x,
    input  logic signed [CoordW-1:0]   s_dir_y,
    input  logic signed [CoordW-1:0]   s_dir_z,
    input  logic                       s_command,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_is_hit,
    output logic [DistW-1:0]           m_distance,
    output logic signed [CoordW-1:0]   m_point_x,
    output logic signed [CoordW-1:0]   m_point_y,
    output logic signed [CoordW-1:0]   m_point_z
);

    localparam int DivStages = DistW;

    // Configuration registers.
    logic [VecW-1:0] corner_reg, edge_a_reg, edge_b_reg, normal_reg;
    logic [LenW-1:0] len_a_reg, len_b_reg;
    logic [EpsW-1:0] eps_reg;
    logic            shadow_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= '0;
            edge_a_reg <= '0;
            edge_b_reg <= '0;
            normal_reg <= '0;
            len_a_reg  <= '0;
            len_b_reg  <= '0;
            eps_reg    <= EpsW'(1);
            shadow_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CORNER: corner_reg <= cfg_data[VecW-1:0];
                REG_EDGE_A: edge_a_reg <= cfg_data[VecW-1:0];
                REG_EDGE_B: edge_b_reg <= cfg_data[VecW-1:0];
                REG_NORMAL: normal_reg <= cfg_data[VecW-1:0];
                REG_LEN_A:  len_a_reg  <= cfg_data[LenW-1:0];
                REG_LEN_B:  len_b_reg  <= cfg_data[LenW-1:0];
                REG_EPS:    eps_reg    <= cfg_data[EpsW-1:0];
                REG_SHADOW: shadow_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic signed [CoordW-1:0] cor [3];
    logic signed [CoordW-1:0] ea  [3];
    logic signed [CoordW-1:0] eb  [3];
    logic signed [CoordW-1:0] nrm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cor[i] = corner_reg[CoordW*i +: CoordW];
            ea[i]  = edge_a_reg[CoordW*i +: CoordW];
            eb[i]  = edge_b_reg[CoordW*i +: CoordW];
            nrm[i] = normal_reg[CoordW*i +: CoordW];
        end
    end

    // One enable for the whole pipeline: it moves whenever the output slot
    // is free or is being emptied in this cycle.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic signed [CoordW-1:0] s_org [3];
    logic signed [CoordW-1:0] s_dir [3];
    assign s_org = '{s_origin_x, s_origin_y, s_origin_z};
    assign s_dir = '{s_dir_x, s_dir_y, s_dir_z};

    // Stage 1: the six products of the two plane dot products.
    logic                       v1_reg, miss1_reg;
    logic signed [CoordW-1:0]   org1_reg [3];
    logic signed [CoordW-1:0]   dir1_reg [3];
    logic signed [CoordW:0]     diff1 [3];
    logic signed [2*CoordW:0]   pn1_reg [3];
    logic signed [2*CoordW-1:0] pd1_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff1[i] = {cor[i][CoordW-1], cor[i]} - {s_org[i][CoordW-1], s_org[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            miss1_reg <= s_command && !shadow_reg;
            for (int i = 0; i < 3; i++) begin
                org1_reg[i] <= s_org[i];
                dir1_reg[i] <= s_dir[i];
                pn1_reg[i]  <= diff1[i] * nrm[i];
                pd1_reg[i]  <= s_dir[i] * nrm[i];
            end
        end
    end

    // Stage 2: numerator and denominator sums.
    logic                     v2_reg, miss2_reg;
    logic signed [CoordW-1:0] org2_reg [3];
    logic signed [CoordW-1:0] dir2_reg [3];
    logic signed [NumW-1:0]   num2_reg;
    logic signed [DenW-1:0]   den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            miss2_reg <= miss1_reg;
            org2_reg  <= org1_reg;
            dir2_reg  <= dir1_reg;
            num2_reg  <= NumW'(pn1_reg[0]) + NumW'(pn1_reg[1]) + NumW'(pn1_reg[2]);
            den2_reg  <= DenW'(pd1_reg[0]) + DenW'(pd1_reg[1]) + DenW'(pd1_reg[2]);
        end
    end

    // Stage 3 feeds the divider. Only a positive quotient can pass epsilon,
    // so opposite signs or a zero denominator are a miss and the division
    // runs on magnitudes. A quotient of 2^32 or more is flagged as saturated.
    typedef struct packed {
        logic [VecW-1:0]  org;
        logic [VecW-1:0]  dir;
        logic             miss;
        logic             sat;
        logic [DMagW-1:0] dmag;
    } div_side_t;

    logic               dv_v_reg   [DivStages+1];
    div_side_t          dv_s_reg   [DivStages+1];
    logic [RemW-1:0]    dv_r_reg   [DivStages+1];
    logic [DistW-1:0]   dv_q_reg   [DivStages+1];
    logic [DistW-1:0]   dv_lo_reg  [DivStages+1];

    logic [NumW-1:0]  num_abs;
    logic [DenW-1:0]  den_abs;
    logic [NMagW-1:0] nmag;
    logic [DMagW-1:0] dmag;
    div_side_t        side2;

    always_comb begin
        num_abs = num2_reg[NumW-1] ? NumW'(-num2_reg) : NumW'(num2_reg);
        den_abs = den2_reg[DenW-1] ? DenW'(-den2_reg) : DenW'(den2_reg);
        nmag    = num_abs[NMagW-1:0];
        dmag    = den_abs[DMagW-1:0];
        side2.org  = {org2_reg[2], org2_reg[1], org2_reg[0]};
        side2.dir  = {dir2_reg[2], dir2_reg[1], dir2_reg[0]};
        side2.miss = miss2_reg || (den2_reg == '0)
                     || (num2_reg[NumW-1] != den2_reg[DenW-1]);
        side2.sat  = {{(DMagW-(NMagW-16)){1'b0}}, nmag[NMagW-1:16]} >= dmag;
        side2.dmag = dmag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_s_reg[0]  <= side2;
            dv_r_reg[0]  <= {{(RemW-(NMagW-16)){1'b0}}, nmag[NMagW-1:16]};
            dv_q_reg[0]  <= '0;
            dv_lo_reg[0] <= {nmag[15:0], 16'h0000};
        end
    end

    // Divider: each stage shifts in one dividend bit and makes one quotient bit.
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        logic [RemW-1:0] rs;
        logic            take;

        always_comb begin
            rs   = {dv_r_reg[k][RemW-2:0], dv_lo_reg[k][DistW-1]};
            take = rs >= {1'b0, dv_s_reg[k].dmag};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_s_reg[k+1]  <= dv_s_reg[k];
                dv_r_reg[k+1]  <= take ? RemW'(rs - {1'b0, dv_s_reg[k].dmag}) : rs;
                dv_q_reg[k+1]  <= {dv_q_reg[k][DistW-2:0], take};
                dv_lo_reg[k+1] <= {dv_lo_reg[k][DistW-2:0], 1'b0};
            end
        end
    end

    // Stage 4: epsilon test on the unsaturated distance, then saturate.
    logic                     v4_reg, miss4_reg;
    logic [DistW-1:0]         ts4_reg;
    logic signed [CoordW-1:0] org4_reg [3];
    logic signed [CoordW-1:0] dir4_reg [3];
    div_side_t                dl;
    logic [DistW-1:0]         dq;

    assign dl = dv_s_reg[DivStages];
    assign dq = dv_q_reg[DivStages];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= dv_v_reg[DivStages];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            miss4_reg <= dl.miss || (!dl.sat && (dq <= {{(DistW-EpsW){1'b0}}, eps_reg}));
            ts4_reg   <= dl.sat ? '1 : dq;
            for (int i = 0; i < 3; i++) begin
                org4_reg[i] <= dl.org[CoordW*i +: CoordW];
                dir4_reg[i] <= dl.dir[CoordW*i +: CoordW];
            end
        end
    end

    // Stage 5: distance times direction.
    logic                            v5_reg, miss5_reg;
    logic [DistW-1:0]                ts5_reg;
    logic signed [CoordW-1:0]        org5_reg [3];
    logic signed [DistW+CoordW:0]    prod5_reg [3];
    logic signed [DistW:0]           ts_s;

    assign ts_s = {1'b0, ts4_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            miss5_reg <= miss4_reg;
            ts5_reg   <= ts4_reg;
            org5_reg  <= org4_reg;
            for (int i = 0; i < 3; i++) begin
                prod5_reg[i] <= ts_s * dir4_reg[i];
            end
        end
    end

    // Stage 6: hit point (floor of the Q16.16 product) and offset from corner.
    logic                   v6_reg, miss6_reg;
    logic [DistW-1:0]       ts6_reg;
    logic signed [PtW-1:0]  pt6_reg  [3];
    logic signed [OffW-1:0] off6_reg [3];
    logic signed [PtW-1:0]  pt6 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt6[i] = {{(PtW-CoordW){org5_reg[i][CoordW-1]}}, org5_reg[i]}
                   + {prod5_reg[i][DistW+CoordW], prod5_reg[i][DistW+CoordW:16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            miss6_reg <= miss5_reg;
            ts6_reg   <= ts5_reg;
            for (int i = 0; i < 3; i++) begin
                pt6_reg[i]  <= pt6[i];
                off6_reg[i] <= {pt6[i][PtW-1], pt6[i]}
                             - {{(OffW-CoordW){cor[i][CoordW-1]}}, cor[i]};
            end
        end
    end

    // Stage 7: edge projection products.
    logic                   v7_reg, miss7_reg;
    logic [DistW-1:0]       ts7_reg;
    logic signed [PtW-1:0]  pt7_reg [3];
    logic signed [PrdW-1:0] pa7_reg [3];
    logic signed [PrdW-1:0] pb7_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (adv) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            miss7_reg <= miss6_reg;
            ts7_reg   <= ts6_reg;
            pt7_reg   <= pt6_reg;
            for (int i = 0; i < 3; i++) begin
                pa7_reg[i] <= off6_reg[i] * ea[i];
                pb7_reg[i] <= off6_reg[i] * eb[i];
            end
        end
    end

    // Output stage: sum the projections, test both against [0, length^2].
    logic signed [DotW-1:0] da, db;
    logic                   hit;

    always_comb begin
        da  = DotW'(pa7_reg[0]) + DotW'(pa7_reg[1]) + DotW'(pa7_reg[2]);
        db  = DotW'(pb7_reg[0]) + DotW'(pb7_reg[1]) + DotW'(pb7_reg[2]);
        hit = !miss7_reg
              && !da[DotW-1] && (da <= $signed({{(DotW-LenW){1'b0}}, len_a_reg}))
              && !db[DotW-1] && (db <= $signed({{(DotW-LenW){1'b0}}, len_b_reg}));
    end

    logic m_valid_reg;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_is_hit   <= hit;
            m_distance <= hit ? ts7_reg : '0;
            m_point_x  <= hit ? sat16(pt7_reg[0]) : '0;
            m_point_y  <= hit ? sat16(pt7_reg[1]) : '0;
            m_point_z  <= hit ? sat16(pt7_reg[2]) : '0;
        end
    end

endmodule
